// ===== src/alr_pkg.sv =====
package alr_pkg;

  // Frame and arithmetic geometry
  localparam int NUM_LANES   = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_RATIO   = 16;
  localparam int RATIO_W     = 21;
  localparam int FRAC_W      = 16;
  localparam int ONE_Q16     = 1 << FRAC_W;
  localparam int HALF_Q16    = 1 << (FRAC_W - 1);
  localparam int RATIO_LO    = ONE_Q16 / MAX_RATIO;
  localparam int RATIO_HI    = MAX_RATIO * ONE_Q16;
  localparam int CNT_W       = $clog2(MAX_RATIO + 1);
  localparam int WIN_LIM     = MAX_RATIO << (SAMPLE_BITS - 1);
  localparam int WS_W        = $clog2(WIN_LIM) + 2;
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int MULA_W      = WS_W;
  localparam int MULB_W      = RATIO_W + 1;
  localparam int PROD_W      = MULA_W + MULB_W;
  localparam int ACC_W       = PROD_W + $clog2(MAX_RATIO);
  localparam int RND_W       = ACC_W - FRAC_W;
  localparam int SUM_W       = RND_W + 1;
  localparam int SMAX        = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SMIN        = -(1 << (SAMPLE_BITS - 1));

  // Configuration port
  localparam int MODE_W    = 2;
  localparam int CC_W      = 3;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam int CC_RESET  = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_COPY    = 2'd0,
    MODE_STRETCH = 2'd1,
    MODE_SHRINK  = 2'd2
  } alr_mode_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE     = 2'd0,
    REG_CHANNELS = 2'd1,
    REG_OPS      = 2'd2,
    REG_SPO      = 2'd3
  } alr_reg_e;

  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_CUR,
    BASE_PREV
  } alr_base_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_LOAD,
    ST_RUN
  } alr_state_e;

  typedef struct packed {
    alr_mode_e          mode;
    logic [RATIO_W-1:0] op;
    logic [RATIO_W-1:0] sp;
  } alr_cfg_t;

  typedef struct packed {
    logic               capture;
    logic               ws_add;
    logic               ws_clear;
    logic               mult;
    logic               sel_win;
    logic [RATIO_W-1:0] mul_ratio;
    logic               load;
    logic               use_prod;
    logic               advance;
    logic               keep_step;
    logic               clear_win;
    alr_base_e          base_sel;
  } alr_lane_cmd_t;

  function automatic logic [RATIO_W-1:0] clamp_ratio(input logic [RATIO_W-1:0] r);
    if (int'(r) < RATIO_LO) begin
      return RATIO_W'(RATIO_LO);
    end else if (int'(r) > RATIO_HI) begin
      return RATIO_W'(RATIO_HI);
    end
    return r;
  endfunction

  function automatic logic signed [WS_W-1:0] clamp_win(input logic signed [WS_W:0] v);
    if (v > $signed((WS_W + 1)'(WIN_LIM))) begin
      return WS_W'(WIN_LIM);
    end else if (v < $signed((WS_W + 1)'(-WIN_LIM))) begin
      return WS_W'(-WIN_LIM);
    end
    return v[WS_W-1:0];
  endfunction

  function automatic sample_t sat_sample(input logic signed [SUM_W-1:0] v);
    if (v > $signed(SUM_W'(SMAX))) begin
      return sample_t'(SMAX);
    end else if (v < $signed(SUM_W'(SMIN))) begin
      return sample_t'(SMIN);
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ===== src/alr_lane.sv =====
module alr_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  alr_pkg::alr_lane_cmd_t cmd_i,
  input  logic                  active_i,
  input  alr_pkg::sample_t      sample_i,
  output alr_pkg::sample_t      value_o
);
  import alr_pkg::*;

  sample_t                   cur_q, prev_q, masked;
  logic signed [WS_W-1:0]    ws_q, ws_base;
  logic signed [WS_W:0]      ws_sum;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [MULA_W-1:0]  mul_a;
  logic signed [MULB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_r;
  logic signed [RND_W-1:0]   rnd;
  sample_t                   base;
  logic signed [SUM_W-1:0]   sum;

  always_comb begin
    masked  = active_i ? sample_i : '0;
    ws_base = cmd_i.ws_clear ? '0 : ws_q;
    ws_sum  = (WS_W + 1)'(ws_base) + (WS_W + 1)'(masked);
    diff    = DIFF_W'(cur_q) - DIFF_W'(prev_q);
    if (cmd_i.sel_win) begin
      mul_a = MULA_W'(ws_q);
    end else begin
      mul_a = MULA_W'(diff);
    end
    mul_b = $signed({1'b0, cmd_i.mul_ratio});
  end

  // Round to nearest, ties up, then add the base sample
  always_comb begin
    acc_r = acc_q + ACC_W'(HALF_Q16);
    rnd   = acc_r[ACC_W-1:FRAC_W];
    case (cmd_i.base_sel)
      BASE_CUR:  base = cur_q;
      BASE_PREV: base = prev_q;
      default:   base = '0;
    endcase
    sum     = SUM_W'(base) + SUM_W'(rnd);
    value_o = sat_sample(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= '0;
    end else if (cmd_i.capture && cmd_i.ws_add) begin
      ws_q <= clamp_win(ws_sum);
    end else if (cmd_i.advance && cmd_i.clear_win) begin
      ws_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      prev_q <= cur_q;
      cur_q  <= masked;
    end
    if (cmd_i.mult) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.load) begin
      acc_q <= cmd_i.use_prod ? ACC_W'(prod_q) : '0;
    end else if (cmd_i.advance) begin
      acc_q <= cmd_i.keep_step ? acc_q + ACC_W'(prod_q) : '0;
    end
  end

endmodule

// ===== src/alr_ctrl.sv =====
module alr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  alr_pkg::alr_cfg_t      cfg_i,
  input  logic                   in_valid_i,
  input  logic                   block_start_i,
  output logic                   in_ready_o,
  input  logic                   slot_free_i,
  output logic                   emit_o,
  output logic                   last_o,
  output alr_pkg::alr_lane_cmd_t cmd_o
);
  import alr_pkg::*;

  alr_state_e             state_q, state_d;
  logic                   have_prev_q, have_prev_d;
  logic [RATIO_W-1:0]     pos_q, pos_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d, k_q, k_d, str_cnt;
  logic                   start, more, last;
  logic [RATIO_W:0]       str_sum, shr_next;
  logic [RATIO_W-FRAC_W:0] str_n;
  logic [RATIO_W-1:0]     shr_d0, shr_d1;

  always_comb begin
    start   = block_start_i | ~have_prev_q;
    str_sum = (RATIO_W + 1)'(pos_q[FRAC_W-1:0]) + (RATIO_W + 1)'(cfg_i.op);
    str_n   = str_sum[RATIO_W:FRAC_W];
    if (str_n > MAX_RATIO) begin
      str_cnt = CNT_W'(MAX_RATIO);
    end else begin
      str_cnt = CNT_W'(str_n);
    end
    shr_d0   = start ? cfg_i.sp : pos_q;
    shr_d1   = (shr_d0 < ONE_Q16) ? '0 : shr_d0 - RATIO_W'(ONE_Q16);
    shr_next = (RATIO_W + 1)'(pos_q) + (RATIO_W + 1)'(cfg_i.sp);
  end

  always_comb begin
    state_d     = state_q;
    have_prev_d = have_prev_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    in_ready_o  = 1'b0;
    emit_o      = 1'b0;
    cmd_o       = '0;

    // Per-mode lane set-up, fixed for the whole item
    case (cfg_i.mode)
      MODE_STRETCH: begin
        cmd_o.base_sel  = BASE_PREV;
        cmd_o.mul_ratio = cfg_i.sp;
        cmd_o.keep_step = 1'b1;
        more            = k_q < cnt_q;
        last            = (k_q + CNT_W'(1)) == cnt_q;
      end
      MODE_SHRINK: begin
        cmd_o.base_sel  = BASE_ZERO;
        cmd_o.sel_win   = 1'b1;
        cmd_o.mul_ratio = cfg_i.op;
        cmd_o.use_prod  = 1'b1;
        cmd_o.clear_win = 1'b1;
        more            = (pos_q < ONE_Q16) && (k_q < CNT_W'(MAX_RATIO));
        last            = (shr_next >= ONE_Q16) || (k_q == CNT_W'(MAX_RATIO - 1));
      end
      default: begin
        cmd_o.base_sel  = BASE_CUR;
        cmd_o.mul_ratio = cfg_i.sp;
        more            = k_q < cnt_q;
        last            = (k_q + CNT_W'(1)) == cnt_q;
      end
    endcase
    last_o = last;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          have_prev_d   = 1'b1;
          k_d           = '0;
          case (cfg_i.mode)
            MODE_STRETCH: begin
              pos_d = RATIO_W'(str_sum[FRAC_W-1:0]);
              cnt_d = start ? '0 : str_cnt;
            end
            MODE_SHRINK: begin
              cmd_o.ws_add   = 1'b1;
              cmd_o.ws_clear = start;
              pos_d          = shr_d1;
            end
            default: begin
              cnt_d = CNT_W'(1);
            end
          endcase
          state_d = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_RUN;
      end
      ST_RUN: begin
        if (!more) begin
          state_d = ST_IDLE;
        end else if (slot_free_i) begin
          emit_o        = 1'b1;
          cmd_o.advance = 1'b1;
          k_d           = k_q + CNT_W'(1);
          if (cfg_i.mode == MODE_SHRINK) begin
            pos_d = shr_next[RATIO_W-1:0];
          end
          if (last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_prev_q <= 1'b0;
      pos_q       <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      have_prev_q <= have_prev_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
    end
  end

endmodule

// ===== src/alr_merge.sv =====
module alr_merge (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  emit_i,
  input  logic                                                  last_i,
  input  logic [alr_pkg::NUM_LANES-1:0][alr_pkg::SAMPLE_BITS-1:0] values_i,
  input  logic [alr_pkg::NUM_LANES-1:0]                         active_i,
  input  logic                                                  out_ready_i,
  output logic                                                  slot_free_o,
  output logic                                                  out_valid_o,
  output logic [alr_pkg::NUM_LANES-1:0][alr_pkg::SAMPLE_BITS-1:0] out_data_o,
  output logic                                                  run_last_o
);
  import alr_pkg::*;

  logic                                     valid_q;
  logic                                     last_q;
  logic [NUM_LANES-1:0][SAMPLE_BITS-1:0]    data_q;

  assign slot_free_o = ~valid_q | out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign run_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Zero the channels beyond the active count
  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      for (int c = 0; c < NUM_LANES; c++) begin
        data_q[c] <= active_i[c] ? values_i[c] : '0;
      end
      last_q <= last_i;
    end
  end

endmodule

// ===== src/audio_length_resampler_unit.sv =====
// Channel   Direction  Handshake                  Payload
// in        sink       in_valid_i / in_ready_o    sample_0_i..sample_3_i, block_start_i
// out       source     out_valid_o / out_ready_i  out_0_o..out_3_o, run_last_o
// config    APB slave  psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// An item passes through capture, multiply and accumulator load, then yields one
// result frame per cycle while the output register is free or being read: one in
// copy mode, up to MAX_RATIO in stretch and shrink; an item that yields no frame
// still passes once through the run state. A new item waits until that run ends.
// Reset clears the registers to copy mode, two channels, unity ratios, and clears the
// position and window sums; the history is ignored until the first frame is taken.
// A stalled output holds the sequencer in its run; the input is taken again as soon
// as the last frame of an item reaches the register.
module audio_length_resampler_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input frames
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [alr_pkg::SAMPLE_BITS-1:0] sample_0_i,
  input  logic signed [alr_pkg::SAMPLE_BITS-1:0] sample_1_i,
  input  logic signed [alr_pkg::SAMPLE_BITS-1:0] sample_2_i,
  input  logic signed [alr_pkg::SAMPLE_BITS-1:0] sample_3_i,
  input  logic                                 block_start_i,
  // Result frames
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [alr_pkg::SAMPLE_BITS-1:0] out_0_o,
  output logic signed [alr_pkg::SAMPLE_BITS-1:0] out_1_o,
  output logic signed [alr_pkg::SAMPLE_BITS-1:0] out_2_o,
  output logic signed [alr_pkg::SAMPLE_BITS-1:0] out_3_o,
  output logic                                 run_last_o,
  // Configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [alr_pkg::PADDR_W-1:0]          paddr,
  input  logic [alr_pkg::PDATA_W-1:0]          pwdata,
  output logic [alr_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);
  import alr_pkg::*;

  logic [MODE_W-1:0]   mode_q;
  logic [CC_W-1:0]     cc_q;
  logic [RATIO_W-1:0]  ops_q, spo_q;
  logic                wr_en;
  alr_reg_e            reg_idx;
  logic [CC_W-1:0]     nch;
  logic [NUM_LANES-1:0] active;
  alr_cfg_t            cfg;
  alr_lane_cmd_t       cmd;
  logic                slot_free, emit, last;
  logic [NUM_LANES-1:0][SAMPLE_BITS-1:0] samples, lane_val, out_data;

  // ---------------------------------------------------------------------------
  // Register file: a transfer completes in the access phase, pready always high
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = alr_reg_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_W'(MODE_COPY);
      cc_q   <= CC_W'(CC_RESET);
      ops_q  <= RATIO_W'(ONE_Q16);
      spo_q  <= RATIO_W'(ONE_Q16);
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODE:     mode_q <= pwdata[MODE_W-1:0];
        REG_CHANNELS: cc_q   <= pwdata[CC_W-1:0];
        REG_OPS:      ops_q  <= pwdata[RATIO_W-1:0];
        REG_SPO:      spo_q  <= pwdata[RATIO_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:     prdata = PDATA_W'(mode_q);
      REG_CHANNELS: prdata = PDATA_W'(cc_q);
      REG_OPS:      prdata = PDATA_W'(ops_q);
      REG_SPO:      prdata = PDATA_W'(spo_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Effective settings: saturate the channel count and both ratios; an unused
  // mode code falls through to copy inside the sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    if (cc_q == '0) begin
      nch = CC_W'(1);
    end else if (int'(cc_q) > NUM_LANES) begin
      nch = CC_W'(NUM_LANES);
    end else begin
      nch = cc_q;
    end
    for (int c = 0; c < NUM_LANES; c++) begin
      active[c] = int'(nch) > c;
    end
    cfg.mode = alr_mode_e'(mode_q);
    cfg.op   = clamp_ratio(ops_q);
    cfg.sp   = clamp_ratio(spo_q);
  end

  // ---------------------------------------------------------------------------
  // Sequencer: position accumulator, run counter and lane commands
  // ---------------------------------------------------------------------------
  alr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .block_start_i (block_start_i),
    .in_ready_o    (in_ready_o),
    .slot_free_i   (slot_free),
    .emit_o        (emit),
    .last_o        (last),
    .cmd_o         (cmd)
  );

  // ---------------------------------------------------------------------------
  // One lane per channel: history, window sum, multiplier and interpolator
  // ---------------------------------------------------------------------------
  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    alr_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .active_i (active[g]),
      .sample_i (samples[g]),
      .value_o  (lane_val[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Merge the lanes into one result frame and hold it until its transfer
  // ---------------------------------------------------------------------------
  alr_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .last_i      (last),
    .values_i    (lane_val),
    .active_i    (active),
    .out_ready_i (out_ready_i),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .run_last_o  (run_last_o)
  );

  assign out_0_o = out_data[0];
  assign out_1_o = out_data[1];
  assign out_2_o = out_data[2];
  assign out_3_o = out_data[3];

endmodule
